/* rtl/core/icy_pkg.sv */
`default_nettype none

package icy_pkg;

  // Largest metadata block, length byte included
  localparam int unsigned META_LIMIT = 1024;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned REMAIN_W   = 12;
  localparam int unsigned KIND_W     = 2;

  // Result kind codes
  localparam logic [KIND_W-1:0] KIND_AUDIO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_META  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR   = 2'd2;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_AUDIO = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_META  = 4'b0100,
    PH_DEAD  = 4'b1000
  } phase_t;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [KIND_W-1:0] kind;
    logic              meta_last;
  } result_t;

  // Parser status seen by the top level checks
  typedef struct packed {
    phase_t              phase;
    logic [REMAIN_W-1:0] meta_remaining;
  } parse_status_t;

endpackage

`default_nettype wire

/* rtl/core/icy_metadata_demux.sv */
`default_nettype none

// ICY metadata splitter. Takes stream body bytes one per transfer and passes
// them on tagged as audio or metadata; the length byte ahead of each
// metadata block is consumed, the last metadata byte of a block has
// meta_last set, and an oversized block gives one error result after which
// everything is dropped until a byte with restart set. One byte is accepted
// every clock cycle when the output side keeps up; a byte passes through
// the input register, then the result register, before its result is
// offered. The rate is set by the parser's counter and phase update,
// which are computed combinationally for each byte.
// Write audio_interval only while no bytes are in flight; zero disables
// splitting. packet_last is accepted but has no effect on parsing.
module icy_metadata_demux import icy_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [INTERVAL_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [BYTE_W-1:0]     in_byte,
  input  wire logic                  restart,
  input  wire logic                  packet_last,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [BYTE_W-1:0]          out_byte,
  output logic [KIND_W-1:0]          kind,
  output logic                       meta_last
);

  logic [INTERVAL_W-1:0] audio_interval;
  logic                  s1_valid;
  logic [BYTE_W-1:0]     s1_byte;
  logic                  s1_restart;
  logic                  advance;
  result_t               res;
  logic                  res_valid;
  parse_status_t         status;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      audio_interval <= '0;
    end else if (cfg_we) begin
      audio_interval <= cfg_data;
    end
  end

  // Input stage moves on whenever the result register is free or draining
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte    <= in_byte;
      s1_restart <= restart;
    end
  end

  icy_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .audio_interval (audio_interval),
    .advance        (advance),
    .in_byte        (s1_byte),
    .restart        (s1_restart),
    .res            (res),
    .res_valid      (res_valid),
    .status         (status)
  );

  icy_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .kind      (kind),
    .meta_last (meta_last)
  );

  // Checks
  a_err_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERR |-> out_byte == '0 && !meta_last)
    else $error("error result with nonzero payload");

  a_last_is_meta: assert property (@(posedge clk) disable iff (rst)
    out_valid && meta_last |-> kind == KIND_META)
    else $error("meta_last on a non-metadata result");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind == KIND_AUDIO || kind == KIND_META || kind == KIND_ERR)
    else $error("undefined result kind");

  a_meta_count: assert property (@(posedge clk) disable iff (rst)
    status.phase == PH_META |-> status.meta_remaining != '0)
    else $error("metadata phase with no bytes remaining");

endmodule

`default_nettype wire

/* rtl/core/icy_parser.sv */
`default_nettype none

module icy_parser import icy_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [INTERVAL_W-1:0] audio_interval,
  input  wire logic                  advance,
  input  wire logic [BYTE_W-1:0]     in_byte,
  input  wire logic                  restart,
  output result_t                    res,
  output logic                       res_valid,
  output parse_status_t              status
);

  phase_t                phase, phase_next;
  logic [INTERVAL_W-1:0] audio_count, audio_count_next;
  logic [REMAIN_W-1:0]   meta_remaining, meta_remaining_next;

  phase_t                ph;
  logic [INTERVAL_W-1:0] cnt;
  logic [INTERVAL_W-1:0] cnt_inc;
  logic [REMAIN_W-1:0]   rem;
  logic [REMAIN_W-1:0]   len;
  logic [REMAIN_W:0]     block_size;

  // Restart clears the state ahead of this byte
  always_comb begin
    ph         = restart ? PH_AUDIO : phase;
    cnt        = restart ? '0 : audio_count;
    rem        = restart ? '0 : meta_remaining;
    cnt_inc    = cnt + 1'b1;
    len        = {in_byte, 4'b0000};
    block_size = {1'b0, len} + 1'b1;
  end

  // Classify the byte and compute the next state
  always_comb begin
    phase_next          = ph;
    audio_count_next    = cnt;
    meta_remaining_next = rem;
    res_valid           = 1'b0;
    res                 = '{out_byte: in_byte, kind: KIND_AUDIO, meta_last: 1'b0};
    if (ph != PH_DEAD && audio_interval == '0) begin
      // splitting off: plain pass-through
      res_valid = 1'b1;
    end else begin
      unique case (ph)
        PH_AUDIO: begin
          res_valid = 1'b1;
          if (cnt_inc >= audio_interval) begin
            audio_count_next = '0;
            phase_next       = PH_LEN;
          end else begin
            audio_count_next = cnt_inc;
          end
        end
        PH_LEN: begin
          if (block_size > (REMAIN_W+1)'(META_LIMIT)) begin
            phase_next = PH_DEAD;
            res_valid  = 1'b1;
            res        = '{out_byte: '0, kind: KIND_ERR, meta_last: 1'b0};
          end else if (len == '0) begin
            phase_next = PH_AUDIO;
          end else begin
            meta_remaining_next = len;
            phase_next          = PH_META;
          end
        end
        PH_META: begin
          res_valid = 1'b1;
          res.kind  = KIND_META;
          if (rem <= REMAIN_W'(1)) begin
            meta_remaining_next = '0;
            phase_next          = PH_AUDIO;
            res.meta_last       = 1'b1;
          end else begin
            meta_remaining_next = rem - 1'b1;
          end
        end
        PH_DEAD: begin
          // drop until restart
        end
        default: begin
          phase_next = PH_AUDIO;
        end
      endcase
    end
  end

  // State registers, updated once per transfer out of the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_AUDIO;
      audio_count    <= '0;
      meta_remaining <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      audio_count    <= audio_count_next;
      meta_remaining <= meta_remaining_next;
    end
  end

  assign status = '{phase: phase, meta_remaining: meta_remaining};

endmodule

`default_nettype wire

/* rtl/core/icy_result_reg.sv */
`default_nettype none

module icy_result_reg import icy_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic              res_valid,
  input  wire result_t           res,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [BYTE_W-1:0]      out_byte,
  output logic [KIND_W-1:0]      kind,
  output logic                   meta_last
);

  result_t held;

  // Valid flag: set on a load with a result, cleared on transfer or on a load without one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign out_byte  = held.out_byte;
  assign kind      = held.kind;
  assign meta_last = held.meta_last;

endmodule

`default_nettype wire

/* verif/tb_icy_metadata_demux.sv */
module tb_icy_metadata_demux;
  import icy_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PCT = 29;
  localparam int unsigned HOLD_AT = 420;
  localparam int unsigned HOLD_LEN = 300;

  // One stream byte as offered to the block
  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              rs;
    logic              pl;
  } stream_byte_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [INTERVAL_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_byte = '0;
  logic                  restart = 1'b0;
  logic                  packet_last = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BYTE_W-1:0]     out_byte;
  logic [KIND_W-1:0]     kind;
  logic                  meta_last;

  stream_byte_t stream_q[$];
  result_t      sorted_q[$];
  stream_byte_t offered;

  // Shadow of the parser
  logic [INTERVAL_W-1:0] split_every = '0;
  phase_t                sh_phase = PH_AUDIO;
  logic [INTERVAL_W-1:0] sh_count = '0;
  logic [REMAIN_W-1:0]   sh_remain = '0;

  int unsigned bytes_in = 0;
  int unsigned bad_count = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;

  icy_metadata_demux dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .restart     (restart),
    .packet_last (packet_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .kind        (kind),
    .meta_last   (meta_last)
  );

  always #5 clk = ~clk;

  task automatic report_error(input string msg);
    $display("ERROR cycle %0d: %s", cycles, msg);
    bad_count++;
  endtask

  task automatic expect_result(input logic [BYTE_W-1:0] b, input logic [KIND_W-1:0] k,
                               input logic last);
    result_t r;
    r.out_byte  = b;
    r.kind      = k;
    r.meta_last = last;
    sorted_q.push_back(r);
  endtask

  // Sort one accepted byte: update shadow state, queue the result if any
  task automatic sort_byte(input logic [BYTE_W-1:0] b, input logic rs);
    int unsigned blk;
    if (rs) begin
      sh_phase  = PH_AUDIO;
      sh_count  = '0;
      sh_remain = '0;
    end
    if (sh_phase == PH_DEAD) begin
      // dropping until restart
    end else if (split_every == 0) begin
      expect_result(b, KIND_AUDIO, 1'b0);
    end else begin
      case (sh_phase)
        PH_AUDIO: begin
          sh_count = sh_count + 1'b1;
          if (sh_count >= split_every) begin
            sh_count = '0;
            sh_phase = PH_LEN;
          end
          expect_result(b, KIND_AUDIO, 1'b0);
        end
        PH_LEN: begin
          blk = b;
          blk = blk * 16;
          if (blk + 1 > META_LIMIT) begin
            sh_phase = PH_DEAD;
            expect_result('0, KIND_ERR, 1'b0);
          end else if (blk == 0) begin
            sh_phase = PH_AUDIO;
          end else begin
            sh_remain = blk[REMAIN_W-1:0];
            sh_phase  = PH_META;
          end
        end
        default: begin
          if (sh_remain <= 1) begin
            sh_remain = '0;
            sh_phase  = PH_AUDIO;
            expect_result(b, KIND_META, 1'b1);
          end else begin
            sh_remain = sh_remain - 1'b1;
            expect_result(b, KIND_META, 1'b0);
          end
        end
      endcase
    end
  endtask

  // Sender: offer queued bytes, idle at random unless calm
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sort_byte(offered.data, offered.rs);
        bytes_in++;
      end
      if (!in_valid || in_ready) begin
        if (stream_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          offered = stream_q.pop_front();
          in_valid    <= 1'b1;
          in_byte     <= offered.data;
          restart     <= offered.rs;
          packet_last <= offered.pl;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transfer, stall at random, one long hold-off
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  result_t     want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (sorted_q.size() == 0) begin
          report_error($sformatf("unexpected result byte %0h kind %0d last %0b",
                                 out_byte, kind, meta_last));
        end else begin
          want = sorted_q.pop_front();
          if (out_byte !== want.out_byte)
            report_error($sformatf("out_byte expected %0h got %0h", want.out_byte, out_byte));
          if (kind !== want.kind)
            report_error($sformatf("kind expected %0d got %0d", want.kind, kind));
          if (meta_last !== want.meta_last)
            report_error($sformatf("meta_last expected %0b got %0b",
                                   want.meta_last, meta_last));
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && bytes_in >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL icy_metadata_demux");
      $finish;
    end
  end

  task automatic push_byte(input int unsigned data, input bit rs);
    stream_byte_t s;
    s.data = data[BYTE_W-1:0];
    s.rs   = rs;
    s.pl   = $urandom_range(1);
    stream_q.push_back(s);
  endtask

  // Wait until every byte is through and nothing is in flight
  task automatic settle();
    do @(posedge clk);
    while (stream_q.size() != 0 || in_valid || sorted_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [INTERVAL_W-1:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    split_every = v;
  endtask

  // Mostly well-formed audio runs and metadata blocks, with stray restarts
  task automatic gen_stream(input int unsigned gap, input int unsigned count);
    int unsigned made;
    int unsigned k;
    int unsigned blen;
    int unsigned pick;
    made = 0;
    while (made < count) begin
      for (k = 0; k < gap && made < count; k++) begin
        push_byte($urandom_range(255), $urandom_range(99) < 2);
        made++;
      end
      if (made < count) begin
        pick = $urandom_range(99);
        if (pick < 8) blen = $urandom_range(255, 64);
        else if (pick < 20) blen = $urandom_range(12, 4);
        else blen = $urandom_range(3, 0);
        push_byte(blen, 1'b0);
        made++;
        if (blen >= 64) begin
          // overflow: a few dropped bytes, then a new stream
          repeat ($urandom_range(4, 1)) push_byte($urandom_range(255), 1'b0);
          push_byte($urandom_range(255), 1'b1);
          made++;
        end else begin
          for (k = 0; k < blen * 16 && made < count; k++) begin
            push_byte($urandom_range(255), $urandom_range(99) < 1);
            made++;
          end
        end
      end
    end
  endtask

  initial begin
    int unsigned k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Splitting off: everything passes as audio
    write_interval(16'd0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hA5, 1'b1);
    settle();

    // Empty block, one short block, overflow, drop, restart
    write_interval(16'd2);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'd1, 1'b0);
    for (k = 0; k < 16; k++) push_byte(k * 17, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'd64, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7E, 1'b1);
    settle();

    // Back-to-back stretch with no idling on either side
    write_interval(16'd3);
    calm = 1'b1;
    gen_stream(3, 160);
    settle();
    calm = 1'b0;

    write_interval(16'd1);
    gen_stream(1, 120);
    settle();

    write_interval(16'hFFFF);
    gen_stream(16'hFFFF, 80);
    settle();

    // Interval now below the running count
    write_interval(16'd7);
    gen_stream(7, 120);
    settle();

    // Splitting off mid-stream, state kept
    write_interval(16'd0);
    gen_stream(5, 80);
    settle();

    write_interval(16'd16);
    gen_stream(16, 160);
    settle();

    // Largest block that still fits, cut short by a new stream
    write_interval(16'd2);
    push_byte($urandom_range(255), 1'b1);
    push_byte($urandom_range(255), 1'b0);
    push_byte(8'd63, 1'b0);
    for (k = 0; k < 20; k++) push_byte($urandom_range(255), 1'b0);
    push_byte($urandom_range(255), 1'b1);
    push_byte($urandom_range(255), 1'b0);
    settle();

    if (bad_count == 0) begin
      $display("PASS icy_metadata_demux");
    end else begin
      $display("FAIL icy_metadata_demux");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/icy_pkg.sv
rtl/core/icy_parser.sv
rtl/core/icy_result_reg.sv
rtl/core/icy_metadata_demux.sv
verif/tb_icy_metadata_demux.sv
